// ===== rtl/core/sorted_priority_queue_core_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue core: assertion macros
// Same-cycle and next-cycle property checks, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spq assertion failed");
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq assertion failed");
`else
`define SPQ_ASSERT(label, clk, rst, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Payload types, entry type, cell control and status/mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int PRIO_W = 8;
  localparam int TAG_W  = 16;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [PRIO_W-1:0] new_priority;
    logic [TAG_W-1:0]  tag;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] out_priority;
    logic [TAG_W-1:0]  out_tag;
    logic [FILL_W-1:0] fill_count;
  } out_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_priority_queue_core.sv =====
// The result is registered and valid in the cycle after the input transfer.
// 1 item per cycle unless output stalls; all cells decide and shift together.
// The output register frees the input while a result is taken in the same cycle.
// Reset: synchronous, clears fill count and output valid; cell contents stay
// undefined until written.
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Bounded stable priority queue built from a row of shift-insert cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_core_macros.svh"

module sorted_priority_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  output logic           in_ready,
  input  spq_pkg::in_t   in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output spq_pkg::out_t  out_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic                       accept;
  logic                       full;
  logic                       empty;
  logic                       do_ins;
  logic                       do_rem;
  spq_pkg::cell_ctl_t         ctl;
  spq_pkg::entry_t            cell_data [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]     cell_ins;
  logic [QUEUE_DEPTH-1:0]     occ;
  spq_pkg::out_t              result;
  logic [CW+spq_pkg::FILL_W-1:0] fill_ext;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_ins   = accept && (in_data.mode == spq_pkg::MODE_INSERT) && !full;
  assign do_rem   = accept && (in_data.mode == spq_pkg::MODE_REMOVE) && !empty;

  assign ctl.insert              = do_ins;
  assign ctl.remove              = do_rem;
  assign ctl.new_entry.prio      = in_data.new_priority;
  assign ctl.new_entry.tag       = in_data.tag;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      spq_pkg::entry_t left_d;
      spq_pkg::entry_t right_d;
      logic            left_i;

      assign occ[g] = (count > CW'(g));

      if (g == 0) begin : g_head
        assign left_d = ctl.new_entry;
        assign left_i = 1'b0;
      end else begin : g_body
        assign left_d = cell_data[g-1];
        assign left_i = cell_ins[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign right_d = cell_data[g];
      end else begin : g_mid
        assign right_d = cell_data[g+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occ[g]),
        .left_data  (left_d),
        .left_ins   (left_i),
        .right_data (right_d),
        .data       (cell_data[g]),
        .ins        (cell_ins[g])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_rem) begin
      count_next = count - CW'(1);
    end
  end

  assign fill_ext = {{spq_pkg::FILL_W{1'b0}}, count_next};

  always_comb begin
    result.status       = spq_pkg::STATUS_OK;
    result.out_priority = '0;
    result.out_tag      = '0;
    result.fill_count   = fill_ext[spq_pkg::FILL_W-1:0];
    if (in_data.mode == spq_pkg::MODE_INSERT) begin
      if (full) begin
        result.status = spq_pkg::STATUS_FULL;
      end
    end else begin
      if (empty) begin
        result.status = spq_pkg::STATUS_EMPTY;
      end else begin
        result.out_priority = cell_data[0].prio;
        result.out_tag      = cell_data[0].tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  `SPQ_ASSERT(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH))
  `SPQ_ASSERT_NEXT(a_ins_count, clk, rst, do_ins, count == CW'($past(count) + CW'(1)))
  `SPQ_ASSERT(a_fill_match, clk, rst, out_valid, out_data.fill_count == fill_ext[spq_pkg::FILL_W-1:0] || accept)
  `SPQ_ASSERT(a_head_order, clk, rst, count >= CW'(2), cell_data[0].prio <= cell_data[1].prio)

endmodule

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One queue slot: shifts right on insert behind the new entry, left on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire                clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  wire                occupied,
  input  spq_pkg::entry_t    left_data,
  input  wire                left_ins,
  input  spq_pkg::entry_t    right_data,
  output spq_pkg::entry_t    data,
  output logic               ins
);

  spq_pkg::entry_t data_next;

  // empty slots count as larger than any priority
  assign ins = !occupied || (data.prio > ctl.new_entry.prio);

  always_comb begin
    data_next = data;
    if (ctl.remove) begin
      data_next = right_data;
    end else if (ctl.insert && ins) begin
      data_next = left_ins ? left_data : ctl.new_entry;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

// ===== tb/sorted_priority_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// Drives insert and remove items through the valid/ready input and checks
// every result against a local model of the stable sorted queue. A directed
// table covers the empty, full, tie and extreme cases. Random traffic follows
// in phases that lean toward filling or draining, with random stalls on both
// sides and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH       = 16;
  localparam int RANDOM_ITEMS = 1030;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_START   = 300;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic                       mode;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::TAG_W-1:0]  tag;
    logic                       typed;
    spq_pkg::out_t              res;
  } stim_row_t;

  localparam spq_pkg::out_t NO_RES = '0;
  localparam int            N_ROWS = 25;

  stim_row_t dir_rows [N_ROWS] = '{
    '{spq_pkg::MODE_REMOVE, 8'd0,   16'h0000, 1'b1,
      '{spq_pkg::STATUS_EMPTY, 8'd0, 16'h0000, 5'd0}},
    '{spq_pkg::MODE_INSERT, 8'd255, 16'hFFFF, 1'b1,
      '{spq_pkg::STATUS_OK,    8'd0, 16'h0000, 5'd1}},
    '{spq_pkg::MODE_INSERT, 8'd0,   16'h0000, 1'b1,
      '{spq_pkg::STATUS_OK,    8'd0, 16'h0000, 5'd2}},
    '{spq_pkg::MODE_INSERT, 8'd0,   16'h1234, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd128, 16'hAAAA, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd128, 16'h5555, 1'b0, NO_RES},
    '{spq_pkg::MODE_REMOVE, 8'd99,  16'h9999, 1'b0, NO_RES},
    '{spq_pkg::MODE_REMOVE, 8'd0,   16'h0000, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd200, 16'h0001, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd3,   16'h0002, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd128, 16'h0003, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd77,  16'h8000, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd255, 16'h7FFF, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd0,   16'hC3C3, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd1,   16'h3C3C, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd254, 16'hDEAD, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd128, 16'h0004, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd64,  16'h0005, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd9,   16'h0006, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd200, 16'h0007, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd127, 16'h0008, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd17,  16'hBEEF, 1'b1,
      '{spq_pkg::STATUS_FULL, 8'd0, 16'h0000, 5'd16}},
    '{spq_pkg::MODE_REMOVE, 8'd255, 16'hFFFF, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd255, 16'h0F0F, 1'b0, NO_RES},
    '{spq_pkg::MODE_INSERT, 8'd0,   16'hF0F0, 1'b1,
      '{spq_pkg::STATUS_FULL, 8'd0, 16'h0000, 5'd16}}
  };

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  spq_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  spq_pkg::out_t out_data;

  spq_pkg::entry_t held [QDEPTH];
  int unsigned     held_count;
  spq_pkg::out_t   pending_results [$];

  int err_count;
  int results_seen;
  int n_insert_ok;
  int n_full;
  int n_remove_ok;
  int n_empty;
  int peak_fill;
  bit src_calm;

  sorted_priority_queue_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic spq_pkg::out_t queue_apply(spq_pkg::in_t item);
    spq_pkg::out_t res;
    int unsigned   pos;
    int unsigned   i;
    res = '0;
    if (item.mode == spq_pkg::MODE_INSERT) begin
      if (held_count >= QDEPTH) begin
        res.status = spq_pkg::STATUS_FULL;
        n_full++;
      end else begin
        pos = 0;
        while (pos < held_count && held[pos].prio <= item.new_priority) pos++;
        for (i = held_count; i > pos; i--) held[i] = held[i-1];
        held[pos].prio = item.new_priority;
        held[pos].tag  = item.tag;
        held_count++;
        n_insert_ok++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = spq_pkg::STATUS_EMPTY;
        n_empty++;
      end else begin
        res.out_priority = held[0].prio;
        res.out_tag      = held[0].tag;
        for (i = 1; i < held_count; i++) held[i-1] = held[i];
        held_count--;
        n_remove_ok++;
      end
    end
    res.fill_count = held_count[spq_pkg::FILL_W-1:0];
    if (held_count > peak_fill) peak_fill = held_count;
    return res;
  endfunction

  task automatic offer_item(input spq_pkg::in_t item, input logic typed,
                            input spq_pkg::out_t typed_res);
    spq_pkg::out_t predicted;
    while (!src_calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = queue_apply(item);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    spq_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          err_count++;
        end
        if (out_data.out_priority !== want.out_priority) begin
          $error("out_priority: expected %0d, got %0d", want.out_priority,
                 out_data.out_priority);
          err_count++;
        end
        if (out_data.out_tag !== want.out_tag) begin
          $error("out_tag: expected %h, got %h", want.out_tag, out_data.out_tag);
          err_count++;
        end
        if (out_data.fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count,
                 out_data.fill_count);
          err_count++;
        end
      end
    end
  end

  initial begin
    int unsigned rcv_cycle;
    out_ready = 1'b0;
    rcv_cycle = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      rcv_cycle++;
      if (rcv_cycle >= HOLD_START && rcv_cycle < HOLD_START + HOLD_CYCLES)
        out_ready <= 1'b0;
      else if (rcv_cycle >= 700 && rcv_cycle < 1000)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(0, 99) >= 20);
      @(negedge clk);
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    @(posedge clk);
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("sorted_priority_queue_core_tb: FAIL");
    $finish;
  end

  initial begin
    spq_pkg::in_t item;
    int unsigned  insert_bias;
    int unsigned  pick;
    clk          = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    held_count   = 0;
    err_count    = 0;
    results_seen = 0;
    n_insert_ok  = 0;
    n_full       = 0;
    n_remove_ok  = 0;
    n_empty      = 0;
    peak_fill    = 0;
    src_calm     = 1'b0;
    insert_bias  = 50;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      item.mode         = dir_rows[r].mode;
      item.new_priority = dir_rows[r].prio;
      item.tag          = dir_rows[r].tag;
      offer_item(item, dir_rows[r].typed, dir_rows[r].res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        pick = $urandom_range(0, 2);
        insert_bias = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
      end
      src_calm = (n >= 400 && n < 600);
      item.mode = ($urandom_range(0, 99) < insert_bias) ? spq_pkg::MODE_INSERT
                                                          : spq_pkg::MODE_REMOVE;
      pick = $urandom_range(0, 9);
      if (pick < 4)
        item.new_priority = 8'($urandom_range(0, 255));
      else if (pick < 8)
        item.new_priority = 8'($urandom_range(0, 7));
      else
        item.new_priority = (pick == 8) ? 8'd0 : 8'd255;
      pick = $urandom_range(0, 19);
      if (pick == 0)
        item.tag = '0;
      else if (pick == 1)
        item.tag = '1;
      else
        item.tag = 16'($urandom_range(0, 65535));
      offer_item(item, 1'b0, NO_RES);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d results: %0d inserts, %0d full refusals, %0d removes,",
             results_seen, n_insert_ok, n_full, n_remove_ok);
    $display("%0d removes from empty, peak fill %0d of %0d", n_empty, peak_fill, QDEPTH);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("sorted_priority_queue_core_tb: PASS");
    end else begin
      $display("sorted_priority_queue_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
